/* rtl/ip_text_address_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of the address parser
// ----------------------------------------------------------------------------
`ifndef IP_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IP_TEXT_ADDRESS_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk_sig
`define ITAP_ASSERT_IMPL(name, clk_sig, dis, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk_sig
`define ITAP_ASSERT_NEXT(name, clk_sig, dis, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/itap_pkg.sv */
// ----------------------------------------------------------------------------
// itap_pkg
// Types, character codes and digit helpers for the text address parser.
// ----------------------------------------------------------------------------
package itap_pkg;

  localparam int NUM_GROUPS     = 8;
  localparam int GROUP_W        = 16;
  localparam int MAX_HEX_DIGITS = 4;
  localparam int MAX_DEC_DIGITS = 3;
  localparam int OCTET_MAX      = 255;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // One character transfer
  typedef struct packed {
    logic [7:0] character;
    logic       is_ipv6;
  } in_t;

  // One result transfer
  typedef struct packed {
    logic        valid_res;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } out_t;

  // Parse outcome captured on the terminating NUL
  typedef struct packed {
    logic                                ok;       // parse phase allowed a result
    logic                                is_v4;    // plain dotted quad result
    logic [NUM_GROUPS-1:0][GROUP_W-1:0]  groups;   // stored groups, in order
    logic [3:0]                          count;    // groups stored
    logic                                gap_seen;
    logic [2:0]                          gap_pos;
  } snap_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Nibble value of a hex character; letters sit at low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  // acc * 10 + d, kept to ten bits
  function automatic logic [9:0] dec_step(input logic [9:0] acc, input logic [3:0] d);
    logic [13:0] t;
    t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, d};
    return t[9:0];
  endfunction

endpackage

/* rtl/ip_text_address_parser.sv */
// The outcome is captured on each NUL and then moved to the output register.
// Throughput: one character per cycle unless the capture register is full and
// stalled; every character updates the parse state directly, and a result held
// in the output register does not block it while the capture register is free.
// Reset (rst, synchronous): returns the parser to the start of a string and
// empties the capture and output registers.
// ----------------------------------------------------------------------------
// ip_text_address_parser
// Streams IPv4/IPv6 address text in and returns the binary address per NUL.
// ----------------------------------------------------------------------------
module ip_text_address_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_ready,
  input  itap_pkg::in_t  char_data,
  output logic           res_valid,
  input  logic           res_ready,
  output itap_pkg::out_t res_data
);

  logic            snap_valid;
  logic            snap_ready;
  itap_pkg::snap_t snap;

  // Character parser with outcome capture
  itap_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // Address assembly and output register
  itap_assemble u_assemble (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule

/* rtl/itap_parser.sv */
// ----------------------------------------------------------------------------
// itap_parser
// Character-at-a-time parse state; captures the outcome on each NUL.
// ----------------------------------------------------------------------------
module itap_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_ready,
  input  itap_pkg::in_t  char_data,
  output logic           snap_valid,
  input  logic           snap_ready,
  output itap_pkg::snap_t snap
);

  typedef enum logic [7:0] {
    PH_START       = 8'b0000_0001,
    PH_LEAD_COLON  = 8'b0000_0010,
    PH_IN_GROUP    = 8'b0000_0100,
    PH_AFTER_COLON = 8'b0000_1000,
    PH_AFTER_GAP   = 8'b0001_0000,
    PH_V4          = 8'b0010_0000,
    PH_V4_TAIL     = 8'b0100_0000,
    PH_ERROR       = 8'b1000_0000
  } phase_t;

  // Parse state
  phase_t                                                    phase;
  logic [itap_pkg::NUM_GROUPS-1:0][itap_pkg::GROUP_W-1:0]    store;
  logic [3:0]  group_count;
  logic        gap_seen;
  logic [2:0]  gap_pos;
  logic [15:0] hex_acc;
  logic [9:0]  dec_acc;
  logic [2:0]  digit_count;
  logic [1:0]  octet_index;
  logic        family_v6;
  logic        letter_seen;

  phase_t                                                    phase_next;
  logic [itap_pkg::NUM_GROUPS-1:0][itap_pkg::GROUP_W-1:0]    store_next;
  logic [3:0]  group_count_next;
  logic        gap_seen_next;
  logic [2:0]  gap_pos_next;
  logic [15:0] hex_acc_next;
  logic [9:0]  dec_acc_next;
  logic [2:0]  digit_count_next;
  logic [1:0]  octet_index_next;
  logic        letter_seen_next;

  itap_pkg::snap_t snap_next;

  logic        accept;
  logic        is_nul;
  logic [7:0]  c;
  logic        fam_eff;
  phase_t      ph_eff;
  logic        c_hex;
  logic        c_dec;
  logic [3:0]  hv;
  logic        octet_ok;
  logic        do_push;
  logic        do_octet;
  logic [1:0]  oct_pos;
  logic [2:0]  oct_slot;
  logic [2:0]  push_slot;

  assign char_ready = !snap_valid || snap_ready;
  assign accept     = char_valid && char_ready;
  assign c          = char_data.character;
  assign is_nul     = (c == itap_pkg::CHAR_NUL);
  assign c_hex      = itap_pkg::is_hex(c);
  assign c_dec      = itap_pkg::is_dec(c);
  assign hv         = itap_pkg::hex_val(c);

  // Family is taken from the first character of a string
  assign fam_eff = (phase == PH_START) ? char_data.is_ipv6 : family_v6;
  assign ph_eff  = ((phase == PH_START) && !char_data.is_ipv6) ? PH_V4 : phase;

  assign octet_ok = (digit_count != 3'd0) &&
                    (digit_count <= 3'(itap_pkg::MAX_DEC_DIGITS)) &&
                    (dec_acc <= 10'(itap_pkg::OCTET_MAX));

  assign push_slot = group_count[2:0];

  // Next state for one character, and the outcome on NUL
  always_comb begin
    phase_next       = ph_eff;
    group_count_next = group_count;
    gap_seen_next    = gap_seen;
    gap_pos_next     = gap_pos;
    hex_acc_next     = hex_acc;
    dec_acc_next     = dec_acc;
    digit_count_next = digit_count;
    octet_index_next = octet_index;
    letter_seen_next = letter_seen;
    do_push          = 1'b0;
    do_octet         = 1'b0;
    oct_pos          = octet_index;
    snap_next.ok       = 1'b0;
    snap_next.is_v4    = 1'b0;
    snap_next.count    = group_count;
    snap_next.gap_seen = gap_seen;
    snap_next.gap_pos  = gap_pos;

    if (is_nul) begin
      // End of string
      unique case (ph_eff)
        PH_IN_GROUP: begin
          do_push         = 1'b1;
          snap_next.ok    = 1'b1;
          snap_next.count = group_count + 4'd1;
        end
        PH_AFTER_GAP: begin
          snap_next.ok = 1'b1;
        end
        PH_V4: begin
          if (octet_ok && (octet_index == 2'd3)) begin
            do_octet        = 1'b1;
            snap_next.ok    = 1'b1;
            snap_next.is_v4 = !fam_eff;
            snap_next.count = group_count + 4'd2;
          end
        end
        PH_V4_TAIL: begin
          snap_next.ok    = 1'b1;
          snap_next.is_v4 = 1'b1;
        end
        default: begin
          snap_next.ok = 1'b0;
        end
      endcase
    end else begin
      unique case (ph_eff)
        PH_START, PH_AFTER_COLON, PH_AFTER_GAP: begin
          if ((ph_eff == PH_START) && (c == itap_pkg::CHAR_COLON)) begin
            phase_next = PH_LEAD_COLON;
          end else if ((ph_eff == PH_AFTER_COLON) && (c == itap_pkg::CHAR_COLON)) begin
            // Second colon: the one zero gap
            if (gap_seen) begin
              phase_next = PH_ERROR;
            end else begin
              gap_seen_next = 1'b1;
              gap_pos_next  = group_count[2:0];
              phase_next    = PH_AFTER_GAP;
            end
          end else if (c_hex) begin
            // Open a new group
            hex_acc_next     = {12'd0, hv};
            dec_acc_next     = c_dec ? {6'd0, hv} : 10'd0;
            digit_count_next = 3'd1;
            letter_seen_next = !c_dec;
            phase_next       = PH_IN_GROUP;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        PH_LEAD_COLON: begin
          if (c == itap_pkg::CHAR_COLON) begin
            gap_seen_next = 1'b1;
            gap_pos_next  = 3'd0;
            phase_next    = PH_AFTER_GAP;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        PH_IN_GROUP: begin
          if (c == itap_pkg::CHAR_COLON) begin
            do_push          = 1'b1;
            group_count_next = group_count + 4'd1;
            phase_next       = (group_count_next >= 4'(itap_pkg::NUM_GROUPS)) ?
                               PH_ERROR : PH_AFTER_COLON;
          end else if (c == itap_pkg::CHAR_DOT) begin
            // Group turns out to be the first octet of an embedded IPv4 part
            if (letter_seen || !octet_ok ||
                (group_count > 4'(itap_pkg::NUM_GROUPS - 2))) begin
              phase_next = PH_ERROR;
            end else begin
              oct_pos          = 2'd0;
              do_octet         = 1'b1;
              octet_index_next = 2'd1;
              digit_count_next = 3'd0;
              dec_acc_next     = 10'd0;
              phase_next       = PH_V4;
            end
          end else if (!c_hex || (digit_count >= 3'(itap_pkg::MAX_HEX_DIGITS))) begin
            phase_next = PH_ERROR;
          end else begin
            hex_acc_next = {hex_acc[11:0], hv};
            if (!c_dec) begin
              letter_seen_next = 1'b1;
            end else if (digit_count < 3'(itap_pkg::MAX_DEC_DIGITS)) begin
              dec_acc_next = itap_pkg::dec_step(dec_acc, hv);
            end
            digit_count_next = digit_count + 3'd1;
          end
        end
        PH_V4: begin
          if (c_dec) begin
            if (digit_count >= 3'(itap_pkg::MAX_DEC_DIGITS)) begin
              phase_next = PH_ERROR;
            end else begin
              dec_acc_next     = itap_pkg::dec_step(dec_acc, hv);
              digit_count_next = digit_count + 3'd1;
            end
          end else if (c == itap_pkg::CHAR_DOT) begin
            if (!octet_ok || (octet_index == 2'd3)) begin
              phase_next = PH_ERROR;
            end else begin
              do_octet         = 1'b1;
              octet_index_next = octet_index + 2'd1;
              digit_count_next = 3'd0;
              dec_acc_next     = 10'd0;
            end
          end else if (c == itap_pkg::CHAR_COLON) begin
            // Only a plain dotted quad may carry an ignored tail
            if (fam_eff || !octet_ok || (octet_index != 2'd3)) begin
              phase_next = PH_ERROR;
            end else begin
              do_octet   = 1'b1;
              phase_next = PH_V4_TAIL;
            end
          end else begin
            phase_next = PH_ERROR;
          end
        end
        default: begin
          phase_next = ph_eff;
        end
      endcase
    end

    // Group store write: a whole group, or one byte of an octet pair
    oct_slot = (fam_eff ? group_count[2:0] : 3'd0) + {2'd0, oct_pos[1]};
    for (int i = 0; i < itap_pkg::NUM_GROUPS; i++) begin
      store_next[i] = store[i];
      if (do_push && (push_slot == 3'(i))) begin
        store_next[i] = hex_acc;
      end else if (do_octet && (oct_slot == 3'(i))) begin
        store_next[i] = oct_pos[0] ? {store[i][15:8], dec_acc[7:0]}
                                   : {dec_acc[7:0], store[i][7:0]};
      end
    end
    snap_next.groups = store_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      group_count <= 4'd0;
      gap_seen    <= 1'b0;
      gap_pos     <= 3'd0;
      hex_acc     <= 16'd0;
      dec_acc     <= 10'd0;
      digit_count <= 3'd0;
      octet_index <= 2'd0;
      family_v6   <= 1'b0;
      letter_seen <= 1'b0;
      snap_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (is_nul) begin
          phase       <= PH_START;
          group_count <= 4'd0;
          gap_seen    <= 1'b0;
          gap_pos     <= 3'd0;
          hex_acc     <= 16'd0;
          dec_acc     <= 10'd0;
          digit_count <= 3'd0;
          octet_index <= 2'd0;
          family_v6   <= 1'b0;
          letter_seen <= 1'b0;
        end else begin
          phase       <= phase_next;
          group_count <= group_count_next;
          gap_seen    <= gap_seen_next;
          gap_pos     <= gap_pos_next;
          hex_acc     <= hex_acc_next;
          dec_acc     <= dec_acc_next;
          digit_count <= digit_count_next;
          octet_index <= octet_index_next;
          family_v6   <= fam_eff;
          letter_seen <= letter_seen_next;
        end
      end
      if (accept && is_nul) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  // Group store and captured outcome (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept && !is_nul) begin
      store <= store_next;
    end
    if (accept && is_nul) begin
      snap <= snap_next;
    end
  end

endmodule

/* rtl/itap_assemble.sv */
// ----------------------------------------------------------------------------
// itap_assemble
// Expands the zero gap, checks the group count and registers the result.
// ----------------------------------------------------------------------------
module itap_assemble (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  output logic            snap_ready,
  input  itap_pkg::snap_t snap,
  output logic            res_valid,
  input  logic            res_ready,
  output itap_pkg::out_t  res_data
);

  logic [itap_pkg::NUM_GROUPS-1:0][itap_pkg::GROUP_W-1:0] g;
  logic [3:0]     zero_len;
  logic [4:0]     gap_lo;
  logic [4:0]     gap_hi;
  logic           v6_ok;
  itap_pkg::out_t res_next;

  assign snap_ready = !res_valid || res_ready;

  // Gap expansion: groups after the gap slide up by the gap length
  always_comb begin
    zero_len = 4'(itap_pkg::NUM_GROUPS) - snap.count;
    gap_lo   = {2'd0, snap.gap_pos};
    gap_hi   = gap_lo + {1'b0, zero_len};
    v6_ok    = snap.gap_seen ? (snap.count < 4'(itap_pkg::NUM_GROUPS))
                             : (snap.count == 4'(itap_pkg::NUM_GROUPS));
    for (int i = 0; i < itap_pkg::NUM_GROUPS; i++) begin
      if (snap.gap_seen && (5'(i) >= gap_lo) && (5'(i) < gap_hi)) begin
        g[i] = '0;
      end else if (snap.gap_seen && (5'(i) >= gap_hi)) begin
        g[i] = snap.groups[3'(3'(i) - zero_len[2:0])];
      end else begin
        g[i] = snap.groups[i];
      end
    end
  end

  // Result word
  always_comb begin
    res_next.valid_res    = 1'b0;
    res_next.address_high = 64'd0;
    res_next.address_low  = 64'd0;
    if (snap.ok && snap.is_v4) begin
      res_next.valid_res   = 1'b1;
      res_next.address_low = {32'd0, snap.groups[0], snap.groups[1]};
    end else if (snap.ok && v6_ok) begin
      res_next.valid_res    = 1'b1;
      res_next.address_high = {g[0], g[1], g[2], g[3]};
      res_next.address_low  = {g[4], g[5], g[6], g[7]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (snap_ready) begin
      res_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      res_data <= res_next;
    end
  end

endmodule

/* rtl/itap_checker.sv */
// ----------------------------------------------------------------------------
// itap_checker
// Port-level checks on the address parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ip_text_address_parser_assert.svh"

module itap_checker (
  input logic           clk,
  input logic           rst,
  input logic           char_valid,
  input logic           char_ready,
  input itap_pkg::in_t  char_data,
  input logic           res_valid,
  input logic           res_ready,
  input itap_pkg::out_t res_data
);

  logic [1:0] pend;
  logic       nul_xfer;
  logic       res_xfer;

  assign nul_xfer = char_valid && char_ready && (char_data.character == itap_pkg::CHAR_NUL);
  assign res_xfer = res_valid && res_ready;

  // Strings ended but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + {1'b0, nul_xfer} - {1'b0, res_xfer};
    end
  end

  `ITAP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_data), "result dropped or changed while stalled")
  `ITAP_ASSERT_IMPL(a_invalid_zero, clk, rst, res_valid && !res_data.valid_res, (res_data.address_high == 64'd0) && (res_data.address_low == 64'd0), "invalid result carries an address")
  `ITAP_ASSERT_IMPL(a_res_owed, clk, rst, res_valid, pend != 2'd0, "result without a terminated string")
  `ITAP_ASSERT_IMPL(a_pend_bound, clk, rst, 1'b1, pend != 2'd3, "more strings outstanding than the pipeline holds")
  `ITAP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !res_valid, "result shown straight after reset")

endmodule

bind ip_text_address_parser itap_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .char_data  (char_data),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res_data   (res_data)
);

/* sim/itap_address_checker.sv */
// ----------------------------------------------------------------------------
// itap_address_checker
// Watches both channels of the text address parser, keeps its own model of
// the character scanner and checks every result transfer against it.
// ----------------------------------------------------------------------------
module itap_address_checker
  import itap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic char_valid,
  input  logic char_ready,
  input  in_t  char_data,
  input  logic res_valid,
  input  logic res_ready,
  input  out_t res_data,
  output int   errors,
  output int   due_count
);

  localparam logic [7:0] CH_0  = "0";
  localparam logic [7:0] CH_9  = "9";
  localparam logic [7:0] CH_LA = "a";
  localparam logic [7:0] CH_LF = "f";
  localparam logic [7:0] CH_UA = "A";
  localparam logic [7:0] CH_UF = "F";

  // Scanner position within one string
  typedef enum logic [2:0] {
    S_BEGIN, S_COLON1, S_GROUP, S_SEP, S_GAP, S_DOTTED, S_TAIL, S_BAD
  } scan_e;

  logic [15:0] grp [8];
  logic [3:0]  n_grp;
  logic [3:0]  gap_at;
  logic        gap_on;
  logic [15:0] hex_sum;
  logic [9:0]  dec_sum;
  logic [2:0]  ndig;
  logic [1:0]  oct_idx;
  scan_e       scan;
  logic        fam6;
  logic        has_letter;

  out_t address_due[$];
  out_t want;

  // Hex digit value, or -1 for anything else
  function automatic int nibble(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic octet_fits();
    return ndig >= 3'd1 && ndig <= 3'd3 && dec_sum <= 10'd255;
  endfunction

  task automatic clear_parser();
    int i;
    for (i = 0; i < 8; i++) grp[i] = '0;
    n_grp      = '0;
    gap_at     = '0;
    gap_on     = 1'b0;
    hex_sum    = '0;
    dec_sum    = '0;
    ndig       = '0;
    oct_idx    = '0;
    scan       = S_BEGIN;
    fam6       = 1'b0;
    has_letter = 1'b0;
  endtask

  // Add a digit to the current group; the decimal view keeps the first three
  task automatic take_hex(input logic [7:0] c);
    int v;
    v = nibble(c);
    if (v < 0 || ndig >= 3'd4) begin
      scan = S_BAD;
    end else begin
      hex_sum = {hex_sum[11:0], 4'(v)};
      if (v >= 10) has_letter = 1'b1;
      else if (ndig < 3'd3) dec_sum = 10'(int'(dec_sum) * 10 + v);
      ndig = ndig + 3'd1;
    end
  endtask

  task automatic open_group(input logic [7:0] c);
    hex_sum    = '0;
    dec_sum    = '0;
    ndig       = '0;
    has_letter = 1'b0;
    scan       = S_GROUP;
    take_hex(c);
  endtask

  task automatic close_group();
    grp[n_grp[2:0]] = hex_sum;
    n_grp = n_grp + 4'd1;
  endtask

  // Octets fill two groups, high byte first; IPv6 places them after the groups
  task automatic put_octet();
    logic [2:0] idx;
    idx = 3'((fam6 ? int'(n_grp) : 0) + int'(oct_idx >> 1));
    if (!oct_idx[0]) grp[idx][15:8] = dec_sum[7:0];
    else grp[idx][7:0] = dec_sum[7:0];
  endtask

  // Expand the gap with zero groups and lay out sixteen bytes
  function automatic out_t v6_address();
    out_t        r;
    logic [15:0] g [8];
    int          n, src, at, i;
    r   = '0;
    n   = int'(n_grp);
    at  = int'(gap_at);
    src = 0;
    if (gap_on ? (n < 8) : (n == 8)) begin
      for (i = 0; i < 8; i++) begin
        if (gap_on && i >= at && i < at + 8 - n) begin
          g[i] = '0;
        end else begin
          g[i] = grp[src & 7];
          src++;
        end
      end
      r.valid_res    = 1'b1;
      r.address_high = {g[0], g[1], g[2], g[3]};
      r.address_low  = {g[4], g[5], g[6], g[7]};
    end
    return r;
  endfunction

  function automatic out_t v4_address();
    out_t r;
    r              = '0;
    r.valid_res    = 1'b1;
    r.address_low  = {32'd0, grp[0], grp[1]};
    return r;
  endfunction

  // Outcome of a string at its terminator
  task automatic close_string(output out_t r);
    r = '0;
    case (scan)
      S_GROUP: begin
        close_group();
        r = v6_address();
      end
      S_GAP: r = v6_address();
      S_DOTTED: begin
        if (octet_fits() && oct_idx == 2'd3) begin
          put_octet();
          if (fam6) begin
            n_grp = n_grp + 4'd2;
            r = v6_address();
          end else begin
            r = v4_address();
          end
        end
      end
      S_TAIL: r = v4_address();
      default: ;
    endcase
  endtask

  // One character transfer; a terminator queues the expected address
  task automatic parse_character(input in_t it);
    logic [7:0] c;
    out_t       r;
    c = it.character;
    if (scan == S_BEGIN) begin
      fam6 = it.is_ipv6;
      if (!fam6) scan = S_DOTTED;
    end
    if (c == CHAR_NUL) begin
      close_string(r);
      address_due.push_back(r);
      clear_parser();
    end else begin
      case (scan)
        S_BEGIN: begin
          if (c == CHAR_COLON) scan = S_COLON1;
          else if (nibble(c) >= 0) open_group(c);
          else scan = S_BAD;
        end
        S_COLON1: begin
          if (c == CHAR_COLON) begin
            gap_on = 1'b1;
            gap_at = '0;
            scan   = S_GAP;
          end else begin
            scan = S_BAD;
          end
        end
        S_GROUP: begin
          if (c == CHAR_COLON) begin
            close_group();
            scan = (n_grp >= 4'd8) ? S_BAD : S_SEP;
          end else if (c == CHAR_DOT) begin
            // embedded dotted part: current group is its first octet
            if (has_letter || !octet_fits() || n_grp > 4'd6) begin
              scan = S_BAD;
            end else begin
              oct_idx = 2'd0;
              put_octet();
              oct_idx = 2'd1;
              ndig    = '0;
              dec_sum = '0;
              scan    = S_DOTTED;
            end
          end else begin
            take_hex(c);
          end
        end
        S_SEP: begin
          if (c == CHAR_COLON) begin
            if (gap_on) begin
              scan = S_BAD;
            end else begin
              gap_on = 1'b1;
              gap_at = n_grp;
              scan   = S_GAP;
            end
          end else if (nibble(c) >= 0) begin
            open_group(c);
          end else begin
            scan = S_BAD;
          end
        end
        S_GAP: begin
          if (nibble(c) >= 0) open_group(c);
          else scan = S_BAD;
        end
        S_DOTTED: begin
          if (c >= CH_0 && c <= CH_9) begin
            if (ndig >= 3'd3) begin
              scan = S_BAD;
            end else begin
              dec_sum = 10'(int'(dec_sum) * 10 + int'(c - CH_0));
              ndig    = ndig + 3'd1;
            end
          end else if (c == CHAR_DOT) begin
            if (!octet_fits() || oct_idx == 2'd3) begin
              scan = S_BAD;
            end else begin
              put_octet();
              oct_idx = oct_idx + 2'd1;
              ndig    = '0;
              dec_sum = '0;
            end
          end else if (c == CHAR_COLON) begin
            // IPv4 only: port or other trailer after the fourth octet
            if (fam6 || !octet_fits() || oct_idx != 2'd3) begin
              scan = S_BAD;
            end else begin
              put_octet();
              scan = S_TAIL;
            end
          end else begin
            scan = S_BAD;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Predict on character transfers, compare on result transfers
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      address_due.delete();
    end else begin
      if (char_valid && char_ready) parse_character(char_data);
      if (res_valid && res_ready) begin
        if (address_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: valid %0b high %h low %h", $time,
                   res_data.valid_res, res_data.address_high, res_data.address_low);
        end else begin
          want = address_due.pop_front();
          if (res_data.valid_res !== want.valid_res) begin
            errors++;
            $display("%0t: valid_res expected %0b actual %0b", $time,
                     want.valid_res, res_data.valid_res);
          end
          if (res_data.address_high !== want.address_high) begin
            errors++;
            $display("%0t: address_high expected %h actual %h", $time,
                     want.address_high, res_data.address_high);
          end
          if (res_data.address_low !== want.address_low) begin
            errors++;
            $display("%0t: address_low expected %h actual %h", $time,
                     want.address_low, res_data.address_low);
          end
        end
      end
    end
    due_count = address_due.size();
  end

endmodule

/* sim/tb_ip_text_address_parser.sv */
// ----------------------------------------------------------------------------
// tb_ip_text_address_parser
// Feeds address strings to the parser one character per transfer: a directed
// set of edge cases, then random well-formed, damaged and noise strings, with
// random idling on both sides, a long result back-pressure stretch and a full
// drain mid-run. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_ip_text_address_parser;
  import itap_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int ITEM_TARGET  = 1950;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [7:0] CH_0  = "0";
  localparam logic [7:0] CH_LA = "a";
  localparam logic [7:0] CH_UA = "A";

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic char_valid = 1'b0;
  logic char_ready;
  in_t  char_data  = '0;
  logic res_valid;
  logic res_ready  = 1'b0;
  out_t res_data;

  int   errors;
  int   due_count;
  int   chars_sent  = 0;
  int   hold_req    = 0;
  int   holds_done  = 0;
  int   hold_cnt;
  int   cycle_count = 0;
  logic calm        = 1'b0;

  ip_text_address_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  itap_address_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .errors    (errors),
    .due_count (due_count)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ip_text_address_parser: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, calm stretch, and counted long hold-offs
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done != hold_req) begin
        res_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        holds_done++;
      end else begin
        res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic text_t to_bytes(input string s);
    text_t q;
    int    i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Characters that stress the scanner: separators, digits, letters, raw bytes
  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 7))
      0:       return CHAR_COLON;
      1:       return CHAR_DOT;
      2:       return CH_0 + 8'($urandom_range(0, 9));
      3:       return CH_LA + 8'($urandom_range(0, 6));
      4:       return CH_UA + 8'($urandom_range(0, 6));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic text_t hex_group();
    text_t q;
    int    n, i, v;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      v = $urandom_range(0, 15);
      if (v < 10) q.push_back(CH_0 + 8'(v));
      else q.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10));
    end
    return q;
  endfunction

  // Four octets, mostly in range, some with leading zeros
  function automatic text_t dotted_quad();
    text_t q;
    int    k, val, w;
    for (k = 0; k < 4; k++) begin
      if (k > 0) q.push_back(CHAR_DOT);
      val = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
      w = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
      if ($urandom_range(0, 3) == 0) w = 3;
      if (w >= 3) q.push_back(CH_0 + 8'(val / 100));
      if (w >= 2) q.push_back(CH_0 + 8'((val / 10) % 10));
      q.push_back(CH_0 + 8'(val % 10));
    end
    return q;
  endfunction

  function automatic text_t v4_text();
    text_t q;
    int    n, i;
    q = dotted_quad();
    if ($urandom_range(0, 3) == 0) begin
      q.push_back(CHAR_COLON);
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) q.push_back(8'($urandom_range(1, 255)));
    end
    return q;
  endfunction

  // Groups around an optional gap, optional dotted tail, now and then one too many
  function automatic text_t v6_text();
    text_t q;
    int    slots, used, left, i;
    logic  gap, dotted;
    dotted = ($urandom_range(0, 3) == 0);
    gap    = 1'($urandom_range(0, 1));
    slots  = dotted ? 6 : 8;
    used   = gap ? $urandom_range(0, slots - 1) : slots;
    if ($urandom_range(0, 9) == 0) used = used + 1;
    left = gap ? $urandom_range(0, used) : used;
    for (i = 0; i < left; i++) begin
      if (i > 0) q.push_back(CHAR_COLON);
      q = {q, hex_group()};
    end
    if (gap) begin
      q.push_back(CHAR_COLON);
      q.push_back(CHAR_COLON);
    end
    for (i = 0; i < used - left; i++) begin
      if (i > 0) q.push_back(CHAR_COLON);
      q = {q, hex_group()};
    end
    if (dotted) begin
      if (used > 0 && !(gap && used == left)) q.push_back(CHAR_COLON);
      q = {q, dotted_quad()};
    end
    return q;
  endfunction

  // Replace, drop or insert one character
  function automatic text_t mangle(input text_t q);
    int pos, op;
    op  = $urandom_range(0, 2);
    pos = (q.size() == 0) ? 0 : $urandom_range(0, q.size() - 1);
    if (q.size() == 0 || op == 2) q.insert(pos, odd_char());
    else if (op == 0) q[pos] = odd_char();
    else q.delete(pos);
    return q;
  endfunction

  function automatic text_t noise_text();
    text_t q;
    int    n, i;
    n = $urandom_range(0, 12);
    for (i = 0; i < n; i++) q.push_back(odd_char());
    return q;
  endfunction

  // One character transfer, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c, input logic fam);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_data  <= '{character: c, is_ipv6: fam};
    char_valid <= 1'b1;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  // Whole string plus terminator; the family flag after the first byte is noise
  task automatic send_text(input text_t txt, input logic fam);
    int i;
    for (i = 0; i <= txt.size(); i++)
      send_char((i < txt.size()) ? txt[i] : CHAR_NUL,
                (i == 0) ? fam : 1'($urandom_range(0, 1)));
  endtask

  // Sender goes quiet until every expected result has been taken
  task automatic wait_drained();
    char_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
  endtask

  initial begin
    text_t txt;
    logic  fam;
    int    pick, k;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: IPv4 extremes, trailer, malformed quads
    send_text(to_bytes("0.0.0.0"), 1'b0);
    send_text(to_bytes("255.255.255.255"), 1'b0);
    send_text(to_bytes("001.02.3.004:80"), 1'b0);
    txt = to_bytes("1.2.3.4:");
    txt.push_back(8'hFF);
    send_text(txt, 1'b0);
    send_text(to_bytes("256.0.0.1"), 1'b0);
    send_text(to_bytes("1.2.3"), 1'b0);
    send_text(to_bytes("1.2.3.4.5"), 1'b0);
    send_text(to_bytes("1234.1.1.1"), 1'b0);
    send_text(to_bytes("1.2.3.4x"), 1'b0);
    send_text(to_bytes(""), 1'b0);

    // Directed: IPv6 gaps, full groups, embedded quads, rejects
    send_text(to_bytes(""), 1'b1);
    send_text(to_bytes("::"), 1'b1);
    send_text(to_bytes("::1"), 1'b1);
    send_text(to_bytes("fFfF::"), 1'b1);
    send_text(to_bytes("0123:4567:89ab:cdef:ABCD:EF01:2345:ffff"), 1'b1);
    send_text(to_bytes(":1::2"), 1'b1);
    send_text(to_bytes("1:2:3:4:5:6:7:8:9"), 1'b1);
    send_text(to_bytes("1:2:3:4::5:6:7:8"), 1'b1);
    send_text(to_bytes("::ffff:192.168.1.255"), 1'b1);
    send_text(to_bytes("1:2:3:4:5:6:1.2.3.4"), 1'b1);
    send_text(to_bytes("1:2:3:4:5:6:7:1.2.3.4"), 1'b1);
    send_text(to_bytes("1::2::3"), 1'b1);
    send_text(to_bytes("12345::"), 1'b1);
    send_text(to_bytes("::a.1.2.3"), 1'b1);
    send_text(to_bytes("::1.2.3.4:5"), 1'b1);
    txt = to_bytes("1:");
    txt.push_back(8'h80);
    send_text(txt, 1'b1);
    send_text(to_bytes("::1"), 1'b0);
    send_text(to_bytes("1.2.3.4"), 1'b1);

    // Random: mostly well-formed, some damaged, some noise
    k = 0;
    while (chars_sent < ITEM_TARGET) begin
      if (k == 15) calm = 1'b1;
      if (k == 30) calm = 1'b0;
      if (k == 40) hold_req++;
      if (k == 60) wait_drained();
      pick = $urandom_range(0, 99);
      fam  = 1'($urandom_range(0, 1));
      if (pick < 60) txt = fam ? v6_text() : v4_text();
      else if (pick < 85) txt = mangle(fam ? v6_text() : v4_text());
      else txt = noise_text();
      if (pick >= 95) fam = ~fam;
      send_text(txt, fam);
      k++;
    end
    char_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("** ip_text_address_parser: PASSED **");
    else $display("** ip_text_address_parser: FAILED **");
    $finish;
  end

endmodule
